// ===== src/kmdc_pkg.sv =====
package kmdc_pkg;

  // One input beat: a record for a way, or an exhaust mark for it.
  typedef struct packed {
    logic        mode;
    logic [2:0]  way;
    logic [63:0] rec_key;
    logic [63:0] rec_value;
    logic        is_tombstone;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic        emit;
    logic [63:0] out_key;
    logic [63:0] out_value;
    logic        fetch_valid;
    logic [2:0]  fetch_way;
    logic        done_res;
    logic [31:0] written_count;
  } out_item_t;

  // Running status of a head scan.
  typedef struct packed {
    logic have;
    logic all_full;
    logic all_done;
  } scan_flags_t;

  localparam logic MODE_RECORD  = 1'b0;
  localparam logic MODE_EXHAUST = 1'b1;

endpackage

// ===== src/kmdc_scan.sv =====
module kmdc_scan #(
  parameter int WAYS       = 8,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        step,
  input  logic [$clog2(WAYS)-1:0]     idx,
  input  logic [KEY_BITS-1:0]         ent_key,
  input  logic [VALUE_BITS-1:0]       ent_value,
  input  logic                        ent_tomb,
  input  logic                        ent_full,
  input  logic                        ent_done,
  output kmdc_pkg::scan_flags_t       flags,
  output logic [$clog2(WAYS)-1:0]     best_idx,
  output logic [KEY_BITS-1:0]         best_key,
  output logic [VALUE_BITS-1:0]       best_value,
  output logic                        best_tomb
);

  kmdc_pkg::scan_flags_t          flags_r, flags_nxt;
  logic [$clog2(WAYS)-1:0]        best_idx_r;
  logic [KEY_BITS-1:0]            best_key_r;
  logic [VALUE_BITS-1:0]          best_value_r;
  logic                           best_tomb_r;
  logic                           take;

  // Shared comparator: later ways win ties.
  assign take = step && !ent_done && ent_full && (!flags_r.have || ent_key <= best_key_r);

  always_comb begin
    flags_nxt = flags_r;
    if (start) begin
      flags_nxt.have     = 1'b0;
      flags_nxt.all_full = 1'b1;
      flags_nxt.all_done = 1'b1;
    end else if (step && !ent_done) begin
      flags_nxt.all_done = 1'b0;
      if (!ent_full) begin
        flags_nxt.all_full = 1'b0;
      end
      if (take) begin
        flags_nxt.have = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r   <= idx;
      best_key_r   <= ent_key;
      best_value_r <= ent_value;
      best_tomb_r  <= ent_tomb;
    end
  end

  assign flags      = flags_r;
  assign best_idx   = best_idx_r;
  assign best_key   = best_key_r;
  assign best_value = best_value_r;
  assign best_tomb  = best_tomb_r;

endmodule

// ===== src/kway_merge_dedup_compactor.sv =====
// K-way merge with duplicate removal for LSM compaction. Each input beat
// either loads the head record of one way or marks that way exhausted; after
// it the block walks the heads of the ways in use with one comparator, one way
// per cycle, and picks the smallest key (the highest way among equal keys).
// A beat is applied at the accepting edge; then the block scans the heads of the
// ways in use through the shared comparator, and then decides and loads the result
// register. in_ready is low from the accepting edge until the decision is made,
// and stays low longer while the decide state waits for the
// output register to be freed by out_ready. A result
// beat is produced when every live way holds a head (the winner is emitted
// unless it repeats the last key or is a tombstone, and its way is asked for
// a refill) or when every way in use is exhausted (done). Otherwise the beat
// produces no result. A finished result waits in the output register while
// the next input beat is taken.
module kway_merge_dedup_compactor #(
  parameter int WAYS       = 8,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kmdc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kmdc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_data
);

  localparam int IDX_W = $clog2(WAYS);
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam int CMP_W = CNT_W + 3;
  localparam int CFG_W = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [3:0]             ways_cfg_r;
  logic [CNT_W-1:0]       n_eff;
  logic [CNT_W-1:0]       n_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   in_fire;
  logic                   in_hit;
  logic [IDX_W-1:0]       widx;
  logic                   scan_last;

  // Head store: one record per way, contents undefined until loaded.
  logic [KEY_BITS-1:0]    head_key_r   [WAYS];
  logic [VALUE_BITS-1:0]  head_value_r [WAYS];
  logic                   head_tomb_r  [WAYS];
  logic [WAYS-1:0]        head_full_r;
  logic [WAYS-1:0]        way_done_r;

  logic [KEY_BITS-1:0]    prev_key_r;
  logic                   prev_key_valid_r;
  logic [31:0]            out_count_r;

  logic                   out_valid_r;
  kmdc_pkg::out_item_t    out_data_r;

  kmdc_pkg::scan_flags_t  flags;
  logic [IDX_W-1:0]       best_idx;
  logic [KEY_BITS-1:0]    best_key;
  logic [VALUE_BITS-1:0]  best_value;
  logic                   best_tomb;

  logic                   fin_res;
  logic                   fin_load;
  logic                   fin_sel;
  logic                   fin_new;
  logic                   fin_emit;
  logic [31:0]            cnt_nxt;
  kmdc_pkg::out_item_t    out_nxt;

  // Configuration: always accepted; write only while no beat is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_cfg_r <= 4'd8;
    end else if (cfg_valid) begin
      ways_cfg_r <= cfg_data;
    end
  end

  // Clamp ways_in_use into 1..WAYS.
  always_comb begin
    if (ways_cfg_r == 4'd0) begin
      n_eff = CNT_W'(1);
    end else if (CFG_W'(ways_cfg_r) > CFG_W'(WAYS)) begin
      n_eff = CNT_W'(WAYS);
    end else begin
      n_eff = CNT_W'(ways_cfg_r);
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_hit    = CMP_W'(in_data.way) < CMP_W'(n_eff);
  assign widx      = IDX_W'(in_data.way);
  assign scan_last = (CNT_W'(idx_r) + CNT_W'(1)) == n_r;

  // Head payload: load a record for a live, in-use way.
  always_ff @(posedge clk) begin
    if (in_fire && in_hit && in_data.mode == kmdc_pkg::MODE_RECORD && !way_done_r[widx]) begin
      head_key_r[widx]   <= in_data.rec_key[KEY_BITS-1:0];
      head_value_r[widx] <= in_data.rec_value[VALUE_BITS-1:0];
      head_tomb_r[widx]  <= in_data.is_tombstone;
    end
  end

  // Head and exhaust flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_full_r <= '0;
      way_done_r  <= '0;
    end else if (in_fire && in_hit) begin
      if (in_data.mode == kmdc_pkg::MODE_RECORD) begin
        if (!way_done_r[widx]) begin
          head_full_r[widx] <= 1'b1;
        end
      end else begin
        // Exhaust mark: drop any waiting head.
        way_done_r[widx]  <= 1'b1;
        head_full_r[widx] <= 1'b0;
      end
    end else if (fin_load && fin_sel) begin
      // Consume the winning head.
      head_full_r[best_idx] <= 1'b0;
    end
  end

  // Head scan through the shared comparator.
  kmdc_scan #(
    .WAYS       (WAYS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_fire),
    .step       (state_r == ST_SCAN),
    .idx        (idx_r),
    .ent_key    (head_key_r[idx_r]),
    .ent_value  (head_value_r[idx_r]),
    .ent_tomb   (head_tomb_r[idx_r]),
    .ent_full   (head_full_r[idx_r]),
    .ent_done   (way_done_r[idx_r]),
    .flags      (flags),
    .best_idx   (best_idx),
    .best_key   (best_key),
    .best_value (best_value),
    .best_tomb  (best_tomb)
  );

  // Result decision, taken from the registered scan status.
  assign fin_sel  = !flags.all_done && flags.all_full && flags.have;
  assign fin_res  = flags.all_done || fin_sel;
  assign fin_load = (state_r == ST_FIN) && fin_res && (!out_valid_r || out_ready);
  assign fin_new  = !prev_key_valid_r || best_key != prev_key_r;
  assign fin_emit = fin_sel && fin_new && !best_tomb;
  assign cnt_nxt  = (fin_emit && out_count_r != '1) ? out_count_r + 32'd1 : out_count_r;

  always_comb begin
    out_nxt               = '0;
    out_nxt.written_count = cnt_nxt;
    if (flags.all_done) begin
      out_nxt.done_res = 1'b1;
    end else begin
      out_nxt.fetch_valid = 1'b1;
      out_nxt.fetch_way   = 3'(best_idx);
      if (fin_emit) begin
        out_nxt.emit      = 1'b1;
        out_nxt.out_key   = 64'(best_key);
        out_nxt.out_value = 64'(best_value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_key_valid_r <= 1'b0;
      prev_key_r       <= '0;
      out_count_r      <= '0;
    end else if (fin_load && fin_sel) begin
      out_count_r <= cnt_nxt;
      if (fin_new) begin
        prev_key_r       <= best_key;
        prev_key_valid_r <= 1'b1;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold while a result has nowhere to go.
        if (!fin_res || fin_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      n_r     <= CNT_W'(1);
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        idx_r <= '0;
        n_r   <= n_eff;
      end else if (state_r == ST_SCAN && !scan_last) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/kway_merge_dedup_compactor_tb.sv =====
module kway_merge_dedup_compactor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmdc_pkg::*;

  localparam int NWAYS = 8;
  // Longest stretch without any beat before declaring a hang. The slowest
  // legal gap is a register write (drain, settle, write).
  localparam int unsigned HANG_LIMIT = 2000;
  // Settle time before a register write: a beat with no result may still be
  // in the head scan.
  localparam int SETTLE_CYCLES = 16;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = 4'd0;

  kway_merge_dedup_compactor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Merge predictor: its own copy of the head records, the exhaust flags, the
  // dedup key and the written-record count, plus the ways_in_use register.
  // ---------------------------------------------------------------------------
  logic [63:0] hd_key   [NWAYS];
  logic [63:0] hd_val   [NWAYS];
  logic        hd_tomb  [NWAYS];
  logic        hd_full  [NWAYS] = '{default: 1'b0};
  logic        run_done [NWAYS] = '{default: 1'b0};
  logic [63:0] prior_key = '0;
  logic        prior_key_ok = 1'b0;
  logic [31:0] wr_count = '0;
  logic [3:0]  ways_reg = 4'd8;

  // Expected result beats, oldest first.
  out_item_t merge_q [$];
  int unsigned n_err = 0;

  // Per-way key cursor, so that each run feeds keys in ascending order.
  logic [63:0] run_pos [NWAYS] = '{default: '0};

  // Toggled by the sender now and then; while set, neither side idles.
  bit calm = 1'b0;

  // Clamp the register: zero acts as one way, anything above NWAYS as NWAYS.
  function automatic int unsigned eff_ways();
    if (ways_reg == 4'd0) return 1;
    if (ways_reg > NWAYS) return NWAYS;
    return ways_reg;
  endfunction

  // Apply one input beat, then make at most one selection. Returns 1 when the
  // beat yields a result, with that result in r.
  function automatic bit merge_step(input in_item_t b, output out_item_t r);
    int unsigned n;
    int unsigned win;
    bit all_full;
    bit all_done;
    bit have;
    n = eff_ways();
    win = 0;
    all_full = 1'b1;
    all_done = 1'b1;
    have = 1'b0;
    r = '0;
    // Ways outside the ones in use are ignored; exhausted ways take no record.
    if (b.way < n) begin
      if (b.mode == MODE_RECORD) begin
        if (!run_done[b.way]) begin
          hd_key[b.way]  = b.rec_key;
          hd_val[b.way]  = b.rec_value;
          hd_tomb[b.way] = b.is_tombstone;
          hd_full[b.way] = 1'b1;
        end
      end else begin
        run_done[b.way] = 1'b1;
        hd_full[b.way]  = 1'b0;
      end
    end
    // Smallest key wins; <= lets the highest (most recent) way take a tie.
    for (int unsigned i = 0; i < n; i++) begin
      if (run_done[i]) continue;
      all_done = 1'b0;
      if (!hd_full[i]) begin
        all_full = 1'b0;
        continue;
      end
      if (!have || hd_key[i] <= hd_key[win]) begin
        win = i;
        have = 1'b1;
      end
    end
    if (all_done) begin
      r.done_res = 1'b1;
      r.written_count = wr_count;
      return 1'b1;
    end
    if (!all_full || !have) return 1'b0;
    // Drop repeats of the last selected key; a tombstone still sets that key.
    if (!prior_key_ok || hd_key[win] != prior_key) begin
      if (!hd_tomb[win]) begin
        r.emit = 1'b1;
        r.out_key = hd_key[win];
        r.out_value = hd_val[win];
        if (wr_count != 32'hFFFF_FFFF) wr_count++;
      end
      prior_key = hd_key[win];
      prior_key_ok = 1'b1;
    end
    hd_full[win] = 1'b0;
    r.fetch_valid = 1'b1;
    r.fetch_way = 3'(win);
    r.written_count = wr_count;
    return 1'b1;
  endfunction

  function automatic bit any_run_left();
    for (int unsigned i = 0; i < eff_ways(); i++)
      if (!run_done[i]) return 1'b1;
    return 1'b0;
  endfunction

  // Draw the next beat. Mostly refill an empty live head with the next key of
  // its run; now and then send noise (random way and key, overwrites of full
  // heads, records for exhausted ways, marks for ways not in use). exh_pct is
  // the chance of exhausting a live way.
  function automatic in_item_t pick_beat(int unsigned exh_pct);
    in_item_t b;
    int unsigned n;
    int unsigned w;
    int unsigned cand[$];
    int unsigned live[$];
    n = eff_ways();
    b.mode = MODE_RECORD;
    b.rec_value = {$urandom, $urandom};
    b.is_tombstone = ($urandom_range(0, 5) == 0);
    for (int unsigned i = 0; i < n; i++) begin
      if (!run_done[i]) begin
        live.insert(live.size(), i);
        if (!hd_full[i]) cand.insert(cand.size(), i);
      end
    end
    if (live.size() != 0 && $urandom_range(0, 99) < exh_pct) begin
      b.mode = MODE_EXHAUST;
      b.way = 3'(live[$urandom_range(0, live.size() - 1)]);
      b.rec_key = {$urandom, $urandom};
      return b;
    end
    if (cand.size() == 0 || $urandom_range(0, 99) < 15) begin
      b.way = 3'($urandom_range(0, NWAYS - 1));
      b.rec_key = $urandom_range(0, 1) ? {$urandom, $urandom}
                                       : run_pos[b.way] + 64'($urandom_range(0, 3));
      // Exhaust marks only where they are ignored, outside the ways in use.
      if (b.way >= n && $urandom_range(0, 1) == 1) b.mode = MODE_EXHAUST;
      return b;
    end
    w = cand[$urandom_range(0, cand.size() - 1)];
    run_pos[w] = run_pos[w] + 64'($urandom_range(0, 3));
    b.way = 3'(w);
    b.rec_key = run_pos[w];
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with known_res set carry a result read straight off
  // the merge rules; the others are checked against the predictor.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    in_item_t  beat;
    logic      known_res;
    out_item_t res;
  } dir_row_t;

  dir_row_t dir_tbl [19];

  function automatic dir_row_t row(logic mode, logic [2:0] way, logic [63:0] key,
                                   logic [63:0] val, logic tomb);
    dir_row_t r;
    r = '0;
    r.beat.mode = mode;
    r.beat.way = way;
    r.beat.rec_key = key;
    r.beat.rec_value = val;
    r.beat.is_tombstone = tomb;
    return r;
  endfunction

  initial begin
    // Fill all eight heads; no result until the last one lands.
    dir_tbl[0]  = row(MODE_RECORD, 3'd0, 64'd0, '1, 1'b0);
    dir_tbl[1]  = row(MODE_RECORD, 3'd1, '1, '1, 1'b0);
    dir_tbl[2]  = row(MODE_RECORD, 3'd2, 64'd5, 64'd0, 1'b0);
    dir_tbl[3]  = row(MODE_RECORD, 3'd3, 64'd0, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
    dir_tbl[4]  = row(MODE_RECORD, 3'd4, 64'd5, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1);
    dir_tbl[5]  = row(MODE_RECORD, 3'd5, 64'd3, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0);
    dir_tbl[6]  = row(MODE_RECORD, 3'd6, 64'h8000_0000_0000_0000, 64'd1, 1'b0);
    // Key zero ties on ways 0, 3 and 7: the newest way wins, and the very
    // first key is written even though it is zero.
    dir_tbl[7]  = row(MODE_RECORD, 3'd7, 64'd0, 64'h1234, 1'b0);
    dir_tbl[7].known_res = 1'b1;
    dir_tbl[7].res = {1'b1, 64'd0, 64'h1234, 1'b1, 3'd7, 1'b0, 32'd1};
    // Same key again from way 7: dropped as a duplicate, way 7 refetched.
    dir_tbl[8]  = row(MODE_RECORD, 3'd7, 64'd0, 64'h55, 1'b0);
    dir_tbl[8].known_res = 1'b1;
    dir_tbl[8].res = {1'b0, 64'd0, 64'd0, 1'b1, 3'd7, 1'b0, 32'd1};
    dir_tbl[9]  = row(MODE_RECORD, 3'd7, 64'd9, 64'h99, 1'b0);
    // Exhaust a way with a full head, then send it a record that is ignored.
    dir_tbl[10] = row(MODE_EXHAUST, 3'd7, '1, '1, 1'b1);
    dir_tbl[11] = row(MODE_RECORD, 3'd7, 64'd1, 64'h11, 1'b0);
    // Tombstone ties a live key and wins on recency: nothing is written.
    dir_tbl[12] = row(MODE_RECORD, 3'd3, 64'd2, 64'h22, 1'b1);
    dir_tbl[13] = row(MODE_RECORD, 3'd0, 64'd2, 64'h23, 1'b0);
    dir_tbl[14] = row(MODE_RECORD, 3'd3, 64'd7, 64'h77, 1'b0);
    dir_tbl[15] = row(MODE_RECORD, 3'd0, 64'd3, 64'h33, 1'b0);
    dir_tbl[16] = row(MODE_RECORD, 3'd5, 64'd4, 64'd0, 1'b0);
    // Largest key and value on several ways.
    dir_tbl[17] = row(MODE_RECORD, 3'd0, '1, 64'd0, 1'b0);
    dir_tbl[18] = row(MODE_RECORD, 3'd5, '1, '1, 1'b0);
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Idle a random number of cycles, present the beat and hold it until it is
  // taken. Valid stays high after acceptance, so a back-to-back beat never
  // lowers and raises it in the same step; whoever pauses next lowers it.
  task automatic send_beat(input in_item_t b, input bit known, input out_item_t known_res);
    int unsigned gap;
    out_item_t r;
    bit has_res;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    has_res = merge_step(b, r);
    if (known) merge_q.insert(merge_q.size(), known_res);
    else if (has_res) merge_q.insert(merge_q.size(), r);
  endtask

  // Hold the sender until every expected beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (merge_q.size() != 0);
  endtask

  // Write ways_in_use once the block is idle.
  task automatic write_ways(input logic [3:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ways_reg = v;
  endtask

  // Run the merge to completion: keep feeding, exhaust live ways now and
  // then until none is left, then a few more beats that must report done.
  task automatic finish_merge();
    while (any_run_left()) send_beat(pick_beat(12), 1'b0, '0);
    repeat (6) send_beat(pick_beat(0), 1'b0, '0);
  endtask

  logic [3:0] phase_cfg [7] = '{4'd15, 4'd1, 4'd0, 4'd5, 4'd8, 4'd2, 4'd7};

  initial begin : stim
    logic [63:0] top;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) send_beat(dir_tbl[i].beat, dir_tbl[i].known_res, dir_tbl[i].res);
    foreach (run_pos[i]) run_pos[i] = 64'd16;

    // Random phases at several register settings, extremes among them.
    foreach (phase_cfg[p]) begin
      write_ways(phase_cfg[p]);
      // Realign the runs so that keys from different ways keep colliding.
      top = '0;
      foreach (run_pos[i]) if (run_pos[i] > top) top = run_pos[i];
      foreach (run_pos[i]) run_pos[i] = top;
      repeat (80) begin
        if ($urandom_range(0, 49) == 0) calm = ~calm;
        if ($urandom_range(0, 59) == 0) drain();
        send_beat(pick_beat(0), 1'b0, '0);
      end
    end

    // Finish the merge on three ways, then widen to bring the untouched
    // ways back in and finish again.
    calm = 1'b0;
    write_ways(4'd3);
    finish_merge();
    write_ways(4'd15);
    repeat (40) send_beat(pick_beat(0), 1'b0, '0);
    finish_merge();

    drain();
    repeat (20) @(posedge clk);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: stall a random number of cycles before each result beat.
  // ---------------------------------------------------------------------------
  initial begin : rx
    int unsigned hold;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic check_field(input string tag, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      n_err++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, tag, want, got);
    end
  endtask

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (merge_q.size() == 0) begin
        n_err++;
        $display("%0t: result beat with nothing expected, expected none, got %h",
                 $time, out_data);
      end else begin
        want = merge_q.pop_front();
        check_field("emit", 64'(want.emit), 64'(out_data.emit));
        check_field("out_key", want.out_key, out_data.out_key);
        check_field("out_value", want.out_value, out_data.out_value);
        check_field("fetch_valid", 64'(want.fetch_valid), 64'(out_data.fetch_valid));
        check_field("fetch_way", 64'(want.fetch_way), 64'(out_data.fetch_way));
        check_field("done_res", 64'(want.done_res), 64'(out_data.done_res));
        check_field("written_count", 64'(want.written_count), 64'(out_data.written_count));
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
